[src/led_twinkle_sparkle_engine_defines.svh]
// ----------------------------------------------------------------------------
// LED twinkle sparkle engine: assertion macros
// Shared property forms for the checker of the sparkle engine.
// ----------------------------------------------------------------------------
`ifndef LED_TWINKLE_SPARKLE_ENGINE_DEFINES_SVH
`define LED_TWINKLE_SPARKLE_ENGINE_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted
`define LTSE_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ltse check failed");

// Next-cycle implication, quiet while reset is asserted
`define LTSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ltse check failed");

`endif

[src/ltse_pkg.sv]
// ----------------------------------------------------------------------------
// ltse_pkg
// Widths, constants, types and helpers of the LED twinkle sparkle engine.
// ----------------------------------------------------------------------------
package ltse_pkg;

  // Field widths
  localparam int unsigned PixelCountW = 9;
  localparam int unsigned PixelIndexW = 8;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned ColorW      = 6;
  localparam int unsigned RngW        = 32;
  localparam int unsigned DividendW   = 16;

  // Defaults for the top-level parameters
  localparam int unsigned MaxPixelsDefault = 256;
  localparam int unsigned SparksDefault    = 5;

  // Reset values
  localparam logic [PixelCountW-1:0] PixelCountReset = 9'd256;
  localparam logic [RngW-1:0]        RngSeed         = 32'd12345;

  // Effect constants
  localparam logic [LevelW-1:0] DecayStep  = 8'd4;
  localparam logic [LevelW-1:0] SparkLevel = 8'hFF;
  localparam int unsigned       ShiftA     = 13;
  localparam int unsigned       ShiftB     = 17;
  localparam int unsigned       ShiftC     = 5;

  // Request function codes
  localparam logic FuncAdvance = 1'b0;
  localparam logic FuncRead    = 1'b1;

  // Modulo unit request and response
  typedef struct packed {
    logic                   start;
    logic [DividendW-1:0]   dividend;
    logic [PixelCountW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                   done;
    logic [PixelCountW-1:0] remainder;
  } mod_rsp_t;

  // One xorshift32 step
  function automatic logic [RngW-1:0] xorshift_step(logic [RngW-1:0] s);
    logic [RngW-1:0] t;
    t = s ^ (s << ShiftA);
    t = t ^ (t >> ShiftB);
    t = t ^ (t << ShiftC);
    return t;
  endfunction

  // Brightness divided by six: multiply by 171/1024, exact for 8-bit inputs
  function automatic logic [ColorW-1:0] div6(logic [LevelW-1:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd171;
    return p[15:10];
  endfunction

endpackage

[src/ltse_req_if.sv]
// ----------------------------------------------------------------------------
// ltse_req_if
// Request channel of the sparkle engine: function code and pixel index.
// ----------------------------------------------------------------------------
interface ltse_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [ltse_pkg::PixelIndexW-1:0]  pixel_index;

  modport source (output valid, output func, output pixel_index, input ready);
  modport sink   (input valid, input func, input pixel_index, output ready);
endinterface

[src/ltse_rsp_if.sv]
// ----------------------------------------------------------------------------
// ltse_rsp_if
// Response channel of the sparkle engine: pixel colour and index error.
// ----------------------------------------------------------------------------
interface ltse_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ltse_pkg::ColorW-1:0]   red;
  logic [ltse_pkg::ColorW-1:0]   green;
  logic [ltse_pkg::LevelW-1:0]   white;
  logic                          index_error;

  modport source (output valid, output red, output green, output white,
                  output index_error, input ready);
  modport sink   (input valid, input red, input green, input white,
                  input index_error, output ready);
endinterface

[src/ltse_mod.sv]
// ----------------------------------------------------------------------------
// ltse_mod
// Iterative remainder unit: 16-bit dividend modulo a 9-bit divisor,
// one quotient bit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module ltse_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltse_pkg::mod_req_t req_i,
  output ltse_pkg::mod_rsp_t rsp_o
);

  localparam int unsigned DW = ltse_pkg::DividendW;
  localparam int unsigned NW = ltse_pkg::PixelCountW;
  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [NW-1:0] div_q, div_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW:0]   trial;
  logic [NW:0]   diff;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial  = {rem_q, dvd_q[DW-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? diff[NW-1:0] : trial[NW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[src/led_twinkle_sparkle_engine.sv]
// ----------------------------------------------------------------------------
// led_twinkle_sparkle_engine
// Per-pixel brightness store with decay, xorshift sparks and colour readout.
// ----------------------------------------------------------------------------
// After reset the block clears its pixel memory, one entry a cycle, and
// takes no request during that pass. A read request does the synchronous
// memory read, then forms the colour into the output register once that
// register is free. A frame advance decays the n active pixels through
// the memory (read one entry while the previous one is written back),
// then works each spark in turn (two generator draws, the bit-serial
// modulo unit, one write), and then posts its all-zero response. One
// request is worked on at a time; a new request is taken while the
// previous response still waits. The user must see that pixel_count is
// written only while the block is idle; the block does not enforce it.
module led_twinkle_sparkle_engine #(
  parameter int unsigned MAX_PIXELS       = ltse_pkg::MaxPixelsDefault,
  parameter int unsigned SPARKS_PER_FRAME = ltse_pkg::SparksDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ltse_pkg::PixelCountW-1:0]   cfg_wdata_i,
  ltse_req_if.sink                           req_i,
  ltse_rsp_if.source                         rsp_o
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned NW = ltse_pkg::PixelCountW;
  localparam int unsigned IW = (AW > NW) ? AW : NW;
  localparam int unsigned SW = (SPARKS_PER_FRAME > 1) ? $clog2(SPARKS_PER_FRAME) : 1;
  localparam int unsigned LW = ltse_pkg::LevelW;
  localparam int unsigned CW = ltse_pkg::ColorW;
  localparam int unsigned RW = ltse_pkg::RngW;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_DECAY   = 3'd2;
  localparam logic [2:0] ST_DRAW_HI = 3'd3;
  localparam logic [2:0] ST_DRAW_LO = 3'd4;
  localparam logic [2:0] ST_MOD     = 3'd5;
  localparam logic [2:0] ST_REPLY   = 3'd6;

  // Pixel memory
  logic [LW-1:0] mem_q [MAX_PIXELS];
  logic [LW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [LW-1:0] mem_wd;

  // Control and datapath registers
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [SW-1:0] spark_q, spark_d;
  logic [RW-1:0] rng_q, rng_d;
  logic [LW-1:0] hi_q, hi_d;
  logic          is_read_q, is_read_d;
  logic          err_q, err_d;
  logic [NW-1:0] pixel_count_q;

  // Response register
  logic          rsp_valid_q, rsp_valid_d;
  logic [CW-1:0] red_q, red_d;
  logic [CW-1:0] green_q, green_d;
  logic [LW-1:0] white_q, white_d;
  logic          ierr_q, ierr_d;

  // Modulo unit
  ltse_pkg::mod_req_t mod_req;
  ltse_pkg::mod_rsp_t mod_rsp;

  logic [NW-1:0] n_active;
  logic [NW-1:0] n_last;
  logic [RW-1:0] rng_next;
  logic          req_fire;
  logic          slot_free;
  logic          decay_last;

  // Clamp the pixel count into 1..MAX_PIXELS
  always_comb begin
    n_active = pixel_count_q;
    if (n_active == '0) begin
      n_active = NW'(1);
    end
    if (32'(n_active) > MAX_PIXELS) begin
      n_active = NW'(MAX_PIXELS);
    end
  end

  assign n_last     = n_active - NW'(1);
  assign decay_last = (IW'(idx_q) == IW'(n_last));
  assign rng_next   = ltse_pkg::xorshift_step(rng_q);
  assign req_fire   = req_i.valid && req_i.ready;
  assign slot_free  = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    spark_d     = spark_q;
    rng_d       = rng_q;
    hi_d        = hi_q;
    is_read_d   = is_read_q;
    err_d       = err_q;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = idx_q;
    mod_req     = '0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    red_d       = red_q;
    green_d     = green_q;
    white_d     = white_q;
    ierr_d      = ierr_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + AW'(1);
        if (idx_q == AW'(MAX_PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.func == ltse_pkg::FuncRead) begin
            is_read_d = 1'b1;
            err_d     = ({1'b0, req_i.pixel_index} >= n_active);
            mem_re    = 1'b1;
            mem_ra    = AW'(req_i.pixel_index);
            state_d   = ST_REPLY;
          end else begin
            is_read_d = 1'b0;
            err_d     = 1'b0;
            mem_re    = 1'b1;
            mem_ra    = '0;
            idx_d     = '0;
            spark_d   = '0;
            state_d   = ST_DECAY;
          end
        end
      end
      ST_DECAY: begin
        // Write back the decayed level, fetch the next pixel
        mem_we = 1'b1;
        mem_wd = (rdata_q > ltse_pkg::DecayStep) ? (rdata_q - ltse_pkg::DecayStep) : '0;
        if (decay_last) begin
          state_d = ST_DRAW_HI;
        end else begin
          mem_re = 1'b1;
          mem_ra = idx_q + AW'(1);
          idx_d  = idx_q + AW'(1);
        end
      end
      ST_DRAW_HI: begin
        rng_d   = rng_next;
        hi_d    = rng_next[LW-1:0];
        state_d = ST_DRAW_LO;
      end
      ST_DRAW_LO: begin
        rng_d            = rng_next;
        mod_req.start    = 1'b1;
        mod_req.dividend = {hi_q, rng_next[LW-1:0]};
        mod_req.divisor  = n_active;
        state_d          = ST_MOD;
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          mem_we  = 1'b1;
          mem_wa  = AW'(mod_rsp.remainder);
          mem_wd  = ltse_pkg::SparkLevel;
          spark_d = spark_q + SW'(1);
          if (spark_q == SW'(SPARKS_PER_FRAME - 1)) begin
            state_d = ST_REPLY;
          end else begin
            state_d = ST_DRAW_HI;
          end
        end
      end
      ST_REPLY: begin
        // Post the response once the output register is free
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          ierr_d      = err_q;
          if (is_read_q && !err_q) begin
            red_d   = rdata_q[LW-1:2];
            green_d = ltse_pkg::div6(rdata_q);
            white_d = rdata_q;
          end else begin
            red_d   = '0;
            green_d = '0;
            white_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      idx_q         <= '0;
      spark_q       <= '0;
      rng_q         <= ltse_pkg::RngSeed;
      pixel_count_q <= ltse_pkg::PixelCountReset;
      is_read_q     <= 1'b0;
      err_q         <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      spark_q     <= spark_d;
      rng_q       <= rng_d;
      is_read_q   <= is_read_d;
      err_q       <= err_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        pixel_count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    red_q   <= red_d;
    green_q <= green_d;
    white_q <= white_d;
    ierr_q  <= ierr_d;
  end

  ltse_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.red         = red_q;
  assign rsp_o.green       = green_q;
  assign rsp_o.white       = white_q;
  assign rsp_o.index_error = ierr_q;

endmodule

[src/ltse_checker.sv]
// ----------------------------------------------------------------------------
// ltse_checker
// Port-level checks on the response channel of the sparkle engine.
// ----------------------------------------------------------------------------
`include "led_twinkle_sparkle_engine_defines.svh"

module ltse_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [ltse_pkg::ColorW-1:0]       rsp_red_i,
  input logic [ltse_pkg::ColorW-1:0]       rsp_green_i,
  input logic [ltse_pkg::LevelW-1:0]       rsp_white_i,
  input logic                              rsp_index_error_i
);

  // Hold a stalled response
  `LTSE_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // Drop all colour on an index error
  `LTSE_ASSERT_NOW(a_err_dark, clk_i, rst_ni, rsp_valid_i && rsp_index_error_i, (rsp_red_i == 6'd0) && (rsp_green_i == 6'd0) && (rsp_white_i == 8'd0))

  // Red is a quarter of white
  `LTSE_ASSERT_NOW(a_red_quarter, clk_i, rst_ni, rsp_valid_i, rsp_red_i == rsp_white_i[7:2])

  // Green is white divided by six
  `LTSE_ASSERT_NOW(a_green_sixth, clk_i, rst_ni, rsp_valid_i, (9'(rsp_green_i) * 9'd6 <= 9'(rsp_white_i)) && (9'(rsp_white_i) - 9'(rsp_green_i) * 9'd6 < 9'd6))

endmodule

bind led_twinkle_sparkle_engine ltse_checker u_ltse_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_red_i         (rsp_o.red),
  .rsp_green_i       (rsp_o.green),
  .rsp_white_i       (rsp_o.white),
  .rsp_index_error_i (rsp_o.index_error)
);
